// File: rtl/core/u8u16_pkg.sv
// Package: beat types, queue bundle type and constants of the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package u8u16_pkg;

	// Most code units that one input byte can cause
	localparam int MAX_UNITS      = 4;
	localparam int UNIT_IDX_W     = $clog2(MAX_UNITS);
	localparam int UNIT_CNT_W     = $clog2(MAX_UNITS + 1);
	localparam int QUEUE_DEPTH_DEF = 4;

	// Byte classification limits
	localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
	localparam logic [7:0]  LEAD_MIN      = 8'hC2;
	localparam logic [7:0]  LEAD_LIMIT    = 8'hF5;
	localparam logic [7:0]  LEAD_3BYTE    = 8'hE0;
	localparam logic [7:0]  LEAD_4BYTE    = 8'hF0;
	localparam logic [7:0]  LEAD_4_TOP    = 8'hF4;
	localparam logic [7:0]  E0_CONT_MAX   = 8'h9F;
	localparam logic [7:0]  F0_CONT_MAX   = 8'h8F;
	localparam logic [7:0]  F4_CONT_MIN   = 8'h90;
	localparam logic [7:0]  CONT_MASK     = 8'hC0;
	localparam logic [7:0]  CONT_TAG      = 8'h80;

	// UTF-16 constants
	localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
	localparam logic [20:0] SUPP_OFFSET    = 21'h10000;
	localparam logic [4:0]  SURR_TOP_BITS  = 5'b11011;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        raw_escape;
		logic        last_of_run;
	} out_beat_t;

	// All units caused by one byte, in order
	typedef struct packed {
		logic [UNIT_CNT_W-1:0]           cnt;
		logic [MAX_UNITS-1:0][15:0]      unit;
		logic [MAX_UNITS-1:0]            esc;
	} bundle_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	// Escape unit for an invalid byte
	function automatic logic [15:0] esc_unit(input logic [7:0] b);
		esc_unit = LOW_SURR_BASE + {8'h00, b};
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		is_cont = (b & CONT_MASK) == CONT_TAG;
	endfunction

endpackage

// File: rtl/core/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 stream decoder.
// Input channel (byte_valid / byte_stall / byte_beat): one UTF-8 byte per beat with an
// end_of_stream flag that flushes an unfinished sequence as escape units.
// Output channel (unit_valid / unit_stall / unit_beat): one UTF-16 code unit per beat;
// raw_escape marks 0xDC00 plus an invalid byte, last_of_run marks the final unit
// caused by one input byte. A byte that only extends a sequence gives no beat.
// The bundle of a byte is written to the queue on the edge that takes the byte and
// is then loaded into the output register, from which its first unit is offered.
// Throughput: one byte per cycle while each byte gives at most one unit and the output
// is not stalled; a byte that gives k units holds the single output register until
// all k are offered. A queue of QUEUE_DEPTH bundles absorbs such bursts; byte_stall
// rises only when that queue is full.
// Reset clears the open sequence, the queue and the output register; no beat is
// offered until a byte arrives. A stalled output beat holds; the front end keeps
// taking bytes until the queue fills.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder import u8u16_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_beat_t  byte_beat,
	output logic      unit_valid,
	input  logic      unit_stall,
	output out_beat_t unit_beat
);

	logic        push;
	logic        pop;
	bundle_t     push_data;
	bundle_t     head;
	queue_stat_t qstat;

	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.push       (push),
		.push_data  (push_data),
		.qstat      (qstat)
	);

	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_beat  (unit_beat)
	);

endmodule

// File: rtl/core/u8u16_front.sv
// Front end: takes input bytes, tracks the open sequence and builds the bundle of units per byte.
`timescale 1ns / 1ps

module u8u16_front import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  in_beat_t    byte_beat,
	output logic        push,
	output bundle_t     push_data,
	input  queue_stat_t qstat
);

	logic [1:0]      held_cnt_q;
	logic [2:0][7:0] held_q;

	logic [1:0]      held_cnt_d;
	logic [2:0][7:0] held_d;
	bundle_t         bnd;
	logic            acc;

	assign byte_stall = qstat.full;
	assign acc        = byte_valid & ~qstat.full;
	assign push       = acc && (bnd.cnt != '0);
	assign push_data  = bnd;

	// Decode one byte against the held sequence
	always_comb begin
		logic [7:0]  b;
		logic [7:0]  h0;
		logic [2:0]  n;
		logic        brk;
		logic        start;
		logic [15:0] v3;
		logic [20:0] full4;

		b     = byte_beat.data_byte;
		h0    = held_q[0];
		n     = '0;
		brk   = 1'b0;
		start = 1'b0;
		bnd   = '0;
		held_d     = held_q;
		held_cnt_d = held_cnt_q;
		v3    = {h0[3:0], held_q[1][5:0], b[5:0]};
		full4 = {h0[2:0], held_q[1][5:0], held_q[2][5:0], b[5:0]} - SUPP_OFFSET;

		case (held_cnt_q)
			2'd0: begin
				start = 1'b1;
			end
			2'd1: begin
				if (!is_cont(b) ||
				    (h0 == LEAD_3BYTE && b <= E0_CONT_MAX) ||
				    (h0 == LEAD_4BYTE && b <= F0_CONT_MAX) ||
				    (h0 == LEAD_4_TOP && b >= F4_CONT_MIN)) begin
					brk = 1'b1;
				end else if (h0 < LEAD_3BYTE) begin
					bnd.unit[n[1:0]] = {5'b00000, h0[4:0], b[5:0]};
					n = n + 3'd1;
					held_cnt_d = 2'd0;
				end else begin
					held_d[1]  = b;
					held_cnt_d = 2'd2;
				end
			end
			2'd2: begin
				if (!is_cont(b)) begin
					brk = 1'b1;
				end else if (h0 < LEAD_4BYTE) begin
					if (v3[15:11] == SURR_TOP_BITS) begin
						brk = 1'b1;
					end else begin
						bnd.unit[n[1:0]] = v3;
						n = n + 3'd1;
						held_cnt_d = 2'd0;
					end
				end else begin
					held_d[2]  = b;
					held_cnt_d = 2'd3;
				end
			end
			default: begin
				if (!is_cont(b)) begin
					brk = 1'b1;
				end else begin
					bnd.unit[n[1:0]] = HIGH_SURR_BASE + {6'd0, full4[19:10]};
					n = n + 3'd1;
					bnd.unit[n[1:0]] = LOW_SURR_BASE + {6'd0, full4[9:0]};
					n = n + 3'd1;
					held_cnt_d = 2'd0;
				end
			end
		endcase

		// Broken sequence: escape every held byte, then restart on this byte
		if (brk) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < held_cnt_q) begin
					bnd.unit[n[1:0]] = esc_unit(held_q[i]);
					bnd.esc[n[1:0]]  = 1'b1;
					n = n + 3'd1;
				end
			end
			held_cnt_d = 2'd0;
			start      = 1'b1;
		end

		if (start) begin
			if (b < ASCII_LIMIT) begin
				bnd.unit[n[1:0]] = {8'h00, b};
				n = n + 3'd1;
			end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
				bnd.unit[n[1:0]] = esc_unit(b);
				bnd.esc[n[1:0]]  = 1'b1;
				n = n + 3'd1;
			end else begin
				held_d[0]  = b;
				held_cnt_d = 2'd1;
			end
		end

		// End of stream flushes whatever is still open
		if (byte_beat.end_of_stream && held_cnt_d != 2'd0) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < held_cnt_d) begin
					bnd.unit[n[1:0]] = esc_unit(held_d[i]);
					bnd.esc[n[1:0]]  = 1'b1;
					n = n + 3'd1;
				end
			end
			held_cnt_d = 2'd0;
		end

		bnd.cnt = n;
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (acc) begin
			held_cnt_q <= held_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			held_q <= held_d;
		end
	end

	// Checks
	a_eos_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && byte_beat.end_of_stream) |=> (held_cnt_q == 2'd0))
		else $error("sequence still open after end of stream");

	a_bundle_size: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_data.cnt <= UNIT_CNT_W'(MAX_UNITS)))
		else $error("bundle holds too many units");

	a_held_or_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !push) |=> (held_cnt_q != 2'd0))
		else $error("byte gave no unit and was not held");

endmodule

// File: rtl/core/u8u16_queue.sv
// Short bundle queue between the decode front end and the unit serialiser.
`timescale 1ns / 1ps

module u8u16_queue import u8u16_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bundle_t     push_data,
	input  logic        pop,
	output bundle_t     head,
	output queue_stat_t qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == CW'(DEPTH));
	assign do_push     = push & ~qstat.full;
	assign do_pop      = pop & ~qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue level beyond depth");

endmodule

// File: rtl/core/u8u16_back.sv
// Back end: walks each queued bundle and drives one code unit per output beat.
`timescale 1ns / 1ps

module u8u16_back import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  queue_stat_t qstat,
	output logic        pop,
	output logic        unit_valid,
	input  logic        unit_stall,
	output out_beat_t   unit_beat
);

	logic                  unit_valid_q;
	out_beat_t             unit_beat_q;
	logic [UNIT_IDX_W-1:0] slot_q;
	logic                  load;
	logic                  last;

	assign unit_valid = unit_valid_q;
	assign unit_beat  = unit_beat_q;

	// Output register free and a bundle waiting
	assign load = ~qstat.empty & (~unit_valid_q | ~unit_stall);
	assign last = (slot_q == UNIT_IDX_W'(head.cnt - 1'b1));
	assign pop  = load & last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_valid_q <= 1'b0;
			slot_q       <= '0;
		end else begin
			if (!unit_valid_q || !unit_stall) begin
				unit_valid_q <= ~qstat.empty;
			end
			if (load) begin
				slot_q <= last ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_beat_q.code_unit   <= head.unit[slot_q];
			unit_beat_q.raw_escape  <= head.esc[slot_q];
			unit_beat_q.last_of_run <= last;
		end
	end

endmodule
